/* sv/pmd_pkg.sv */
// Shared types and constants for the PID motor drive controller.
// Used by pid_motor_drive_controller_core and the bench; depends on nothing.
package pmd_pkg;

  localparam int MEAS_W   = 16;
  localparam int DT_W     = 16;
  localparam int GAIN_W   = 16;
  localparam int POWER_W  = 8;
  localparam int PID_W    = 9;
  localparam int DIR_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int INTEG_W = 26;
  localparam int DIV_W   = 48;
  localparam int RATE_W  = 48;

  localparam int DIV_STEPS = 48;
  localparam int MUL_STEPS = 16;

  localparam logic [9:0]  MS_PER_S  = 10'd1000;
  localparam logic [10:0] MS_DIVISOR = 11'd1000;

  localparam logic signed [40:0] INT_LIM_WIDE = 41'sd16711680;
  localparam logic signed [INTEG_W-1:0] INT_LIM = 26'sd16711680;
  localparam logic signed [63:0] OUT_LIM_Q24 = 64'sd4261412864;
  localparam logic signed [63:0] OUT_NEG_Q24 = -64'sd4261412864;
  localparam logic [PID_W-1:0] PID_POS_MAX = 9'h0FE;
  localparam logic [PID_W-1:0] PID_NEG_MAX = 9'h102;
  localparam logic [RATE_W-1:0] RATE_SAT_POS = 48'h4000_0000_0000;
  localparam logic [RATE_W-1:0] RATE_SAT_NEG = 48'hC000_0000_0000;

  typedef enum logic [1:0] {
    MODE_STEER   = 2'd0,
    MODE_FOLLOW  = 2'd1,
    MODE_ENCODER = 2'd2,
    MODE_SPIN    = 2'd3
  } mode_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_POWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 3'd5;

endpackage

/* sv/pid_motor_drive_controller_core.sv */
// PID motor drive controller: bit-serial dividers and multipliers, sequencer,
// output register and configuration registers.
// Depends on pmd_pkg.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write registers only while no request is in flight.
//   Input: s_axis_* carries {elapsed_ms, measurement}; one request at a time.
//   Output: m_axis_* carries one result per request.
//   Sequence: the two 48-step restoring dividers (integral increment over 1000
//   and derivative over elapsed_ms, run side by side), then 16 steps of the
//   three serial gain multipliers, two additions, clamp and emit. A new request
//   is taken only once the previous one has left the sequencer.
//   The result sits in an output register, so the next request is accepted
//   while a result waits. If the receiver stalls, the following result holds
//   in the sequencer until the output register is free.
//   Reset (rst, synchronous) clears the configuration registers, the integral
//   and the previous error, and drops m_axis_tvalid.
module pid_motor_drive_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] measurement, [31:16] elapsed_ms
  input  logic [pmd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [8:0] pid_value, [9] drive_update, [11:10] chan_a_dir, [13:12] chan_b_dir,
  // [21:14] chan_a_power, [29:22] chan_b_power, [31:30] zero
  output logic [pmd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import pmd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_POST, ST_MUL, ST_ADD1, ST_ADD2, ST_CLAMP, ST_EMIT
  } state_t;

  state_t state;
  logic [5:0] count;

  mode_t                     mode;
  logic [MEAS_W-1:0]         setpoint;
  logic [POWER_W-1:0]        base_power;
  logic [GAIN_W-1:0]         kp_gain;
  logic [GAIN_W-1:0]         ki_gain;
  logic [GAIN_W-1:0]         kd_gain;

  logic [INTEG_W-1:0]        integral_acc;
  logic [ERR_W-1:0]          previous_error;

  logic [ERR_W-1:0]          err;
  logic [DIFF_W-1:0]         diff;
  logic [DT_W-1:0]           dt;

  logic [DIV_W-1:0]          dq_a;
  logic [9:0]                rem_a;
  logic [DIV_W-1:0]          dq_b;
  logic [DT_W-1:0]           rem_b;

  logic [INTEG_W-1:0]        integ_hold;
  logic                      zero_out;

  logic [INTEG_W-1:0]        xb;
  logic [RATE_W-1:0]         xc;
  logic [ERR_W:0]            pa;
  logic [INTEG_W:0]          pb;
  logic [RATE_W:0]           pc;
  logic [GAIN_W-1:0]         la;
  logic [GAIN_W-1:0]         lb;
  logic [GAIN_W-1:0]         lc;
  logic [GAIN_W-1:0]         ga;
  logic [GAIN_W-1:0]         gb;
  logic [GAIN_W-1:0]         gc;

  logic [63:0]               sum;
  logic [PID_W-1:0]          o_val;

  logic [PID_W-1:0]          out_pid;
  logic                      out_upd;
  logic [DIR_W-1:0]          out_a_dir;
  logic [DIR_W-1:0]          out_b_dir;
  logic [POWER_W-1:0]        out_a_pow;
  logic [POWER_W-1:0]        out_b_pow;

  // request decode
  logic [MEAS_W-1:0]  meas_in;
  logic [DT_W-1:0]    dt_in;
  logic [ERR_W-1:0]   err_in;
  logic [DIFF_W-1:0]  diff_in;

  assign meas_in = s_axis_tdata[15:0];
  assign dt_in   = s_axis_tdata[31:16];
  assign err_in  = {setpoint[MEAS_W-1], setpoint} - {meas_in[MEAS_W-1], meas_in};
  assign diff_in = {err_in[ERR_W-1], err_in} - {previous_error[ERR_W-1], previous_error};

  // dividend setup
  logic [ERR_W-1:0]  err_neg;
  logic [DIFF_W-1:0] diff_neg;
  logic [15:0]       err_mag;
  logic [16:0]       diff_mag;
  logic [31:0]       prod_a;
  logic [26:0]       prod_b;

  assign err_neg  = -err;
  assign diff_neg = -diff;
  assign err_mag  = err[ERR_W-1] ? err_neg[15:0] : err[15:0];
  assign diff_mag = diff[DIFF_W-1] ? diff_neg[16:0] : diff[16:0];
  assign prod_a   = err_mag * dt;
  assign prod_b   = diff_mag * MS_PER_S;

  // restoring divider steps
  logic [10:0] num_a;
  logic [10:0] sub_a;
  logic        ge_a;
  logic [16:0] num_b;
  logic [16:0] sub_b;
  logic        ge_b;

  assign num_a = {rem_a, dq_a[DIV_W-1]};
  assign sub_a = num_a - MS_DIVISOR;
  assign ge_a  = num_a >= MS_DIVISOR;
  assign num_b = {rem_b, dq_b[DIV_W-1]};
  assign sub_b = num_b - {1'b0, dt};
  assign ge_b  = num_b >= {1'b0, dt};

  // integral and derivative from quotients
  logic [39:0]        inc;
  logic [40:0]        integ;
  logic               integ_oor;
  logic [RATE_W-1:0]  rate;

  always_comb begin
    inc = err[ERR_W-1] ? -{1'b0, dq_a[38:0]} : {1'b0, dq_a[38:0]};
    integ = {{15{integral_acc[INTEG_W-1]}}, integral_acc} + {inc[39], inc};
    integ_oor = ($signed(integ) > INT_LIM_WIDE) || ($signed(integ) < -INT_LIM_WIDE);
    if (dt == '0) begin
      if (diff == '0) begin
        rate = '0;
      end else if (diff[DIFF_W-1]) begin
        rate = RATE_SAT_NEG;
      end else begin
        rate = RATE_SAT_POS;
      end
    end else if (diff[DIFF_W-1]) begin
      rate = -{5'b0, dq_b[42:0]};
    end else begin
      rate = {5'b0, dq_b[42:0]};
    end
  end

  // serial-parallel multiplier steps, gain bit LSB first
  logic              mul_last;
  logic [ERR_W+1:0]   xa_ext;
  logic [ERR_W+1:0]   add_a;
  logic [ERR_W+1:0]   ta;
  logic [INTEG_W+1:0] xb_ext;
  logic [INTEG_W+1:0] add_b;
  logic [INTEG_W+1:0] tb;
  logic [RATE_W+1:0]  xc_ext;
  logic [RATE_W+1:0]  add_c;
  logic [RATE_W+1:0]  tc;

  always_comb begin
    mul_last = count == 6'(MUL_STEPS - 1);
    xa_ext = {{2{err[ERR_W-1]}}, err};
    xb_ext = {{2{xb[INTEG_W-1]}}, xb};
    xc_ext = {{2{xc[RATE_W-1]}}, xc};
    add_a = ga[0] ? (mul_last ? -xa_ext : xa_ext) : '0;
    add_b = gb[0] ? (mul_last ? -xb_ext : xb_ext) : '0;
    add_c = gc[0] ? (mul_last ? -xc_ext : xc_ext) : '0;
    ta = {pa[ERR_W], pa} + add_a;
    tb = {pb[INTEG_W], pb} + add_b;
    tc = {pc[RATE_W], pc} + add_c;
  end

  // product alignment
  logic [33:0] prod_pa;
  logic [42:0] prod_pb;
  logic [64:0] prod_pc;
  logic [63:0] sa64;
  logic [63:0] sb64;

  assign prod_pa = {pa, la};
  assign prod_pb = {pb, lb};
  assign prod_pc = {pc, lc};
  assign sa64    = {{14{prod_pa[33]}}, prod_pa, 16'b0};
  assign sb64    = {{21{prod_pb[42]}}, prod_pb};

  // clamp and truncate toward zero
  logic [32:0]      biased;
  logic [PID_W-1:0] o_clamp;

  always_comb begin
    biased = sum[32:0] + (sum[63] ? 33'h0FF_FFFF : 33'h0);
    if ($signed(sum) > OUT_LIM_Q24) begin
      o_clamp = PID_POS_MAX;
    end else if ($signed(sum) < OUT_NEG_Q24) begin
      o_clamp = PID_NEG_MAX;
    end else begin
      o_clamp = biased[32:24];
    end
  end

  // motor channel mapping
  function automatic logic [POWER_W-1:0] sat_u8(input logic [9:0] v);
    logic [POWER_W-1:0] r;
    if (v[9]) begin
      r = '0;
    end else if (v[8]) begin
      r = '1;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic [PID_W-1:0]   o_neg;
  logic [POWER_W-1:0] o_mag;
  logic               o_pos;
  logic               o_is_neg;
  logic [9:0]         base_plus;
  logic [9:0]         base_minus;
  logic               map_upd;
  logic [DIR_W-1:0]   map_a_dir;
  logic [DIR_W-1:0]   map_b_dir;
  logic [POWER_W-1:0] map_a_pow;
  logic [POWER_W-1:0] map_b_pow;

  always_comb begin
    o_neg      = -o_val;
    o_is_neg   = o_val[PID_W-1];
    o_pos      = !o_is_neg && (o_val != '0);
    o_mag      = o_is_neg ? o_neg[7:0] : o_val[7:0];
    base_plus  = {2'b0, base_power} + {o_val[PID_W-1], o_val};
    base_minus = {2'b0, base_power} - {o_val[PID_W-1], o_val};
    map_upd    = 1'b0;
    map_a_dir  = DIR_STOP;
    map_b_dir  = DIR_STOP;
    map_a_pow  = '0;
    map_b_pow  = '0;
    unique case (mode)
      MODE_STEER: begin
        map_upd   = 1'b1;
        map_a_dir = DIR_FWD;
        map_b_dir = DIR_FWD;
        map_a_pow = sat_u8(base_minus);
        map_b_pow = sat_u8(base_plus);
      end
      MODE_FOLLOW: begin
        if (o_is_neg) begin
          map_upd   = 1'b1;
          map_a_dir = DIR_FWD;
          map_b_dir = DIR_FWD;
          map_a_pow = sat_u8(base_plus);
          map_b_pow = sat_u8(base_plus);
        end else if (o_pos) begin
          map_upd   = 1'b1;
          map_a_dir = DIR_BACK;
          map_b_dir = DIR_BACK;
          map_a_pow = o_mag;
          map_b_pow = o_mag;
        end
      end
      MODE_ENCODER: begin
        if (o_pos) begin
          map_upd   = 1'b1;
          map_a_dir = DIR_FWD;
          map_b_dir = DIR_FWD;
          map_a_pow = o_mag;
          map_b_pow = o_mag;
        end else if (o_is_neg) begin
          map_upd = 1'b1;
        end
      end
      MODE_SPIN: begin
        if (o_pos) begin
          map_upd   = 1'b1;
          map_a_dir = DIR_FWD;
          map_b_dir = DIR_BACK;
          map_a_pow = o_mag;
          map_b_pow = o_mag;
        end else if (o_is_neg) begin
          map_upd   = 1'b1;
          map_a_dir = DIR_BACK;
          map_b_dir = DIR_FWD;
          map_a_pow = o_mag;
          map_b_pow = o_mag;
        end
      end
    endcase
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tdata  = {2'b0, out_b_pow, out_a_pow, out_b_dir, out_a_dir, out_upd, out_pid};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      m_axis_tvalid  <= 1'b0;
      mode           <= MODE_STEER;
      setpoint       <= '0;
      base_power     <= '0;
      kp_gain        <= '0;
      ki_gain        <= '0;
      kd_gain        <= '0;
      integral_acc   <= '0;
      previous_error <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:       mode       <= mode_t'(cfg_data[1:0]);
          REG_SETPOINT:   setpoint   <= cfg_data;
          REG_BASE_POWER: base_power <= cfg_data[POWER_W-1:0];
          REG_KP_GAIN:    kp_gain    <= cfg_data;
          REG_KI_GAIN:    ki_gain    <= cfg_data;
          REG_KD_GAIN:    kd_gain    <= cfg_data;
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && (state != ST_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            err   <= err_in;
            diff  <= diff_in;
            dt    <= dt_in;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          dq_a  <= {prod_a, 16'b0};
          dq_b  <= {5'b0, prod_b, 16'b0};
          rem_a <= '0;
          rem_b <= '0;
          count <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dq_a  <= {dq_a[DIV_W-2:0], ge_a};
          rem_a <= ge_a ? sub_a[9:0] : num_a[9:0];
          dq_b  <= {dq_b[DIV_W-2:0], ge_b};
          rem_b <= ge_b ? sub_b[15:0] : num_b[15:0];
          count <= count + 6'd1;
          if (count == 6'(DIV_STEPS - 1)) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          zero_out   <= integ_oor || (err == '0);
          integ_hold <= (integ_oor || (err == '0)) ? '0 : integ[INTEG_W-1:0];
          xb    <= integ[INTEG_W-1:0];
          xc    <= rate;
          pa    <= '0;
          pb    <= '0;
          pc    <= '0;
          la    <= '0;
          lb    <= '0;
          lc    <= '0;
          ga    <= kp_gain;
          gb    <= ki_gain;
          gc    <= kd_gain;
          count <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          pa    <= ta[ERR_W+1:1];
          la    <= {ta[0], la[GAIN_W-1:1]};
          pb    <= tb[INTEG_W+1:1];
          lb    <= {tb[0], lb[GAIN_W-1:1]};
          pc    <= tc[RATE_W+1:1];
          lc    <= {tc[0], lc[GAIN_W-1:1]};
          ga    <= ga >> 1;
          gb    <= gb >> 1;
          gc    <= gc >> 1;
          count <= count + 6'd1;
          if (mul_last) begin
            state <= ST_ADD1;
          end
        end
        ST_ADD1: begin
          sum   <= sa64 + sb64;
          state <= ST_ADD2;
        end
        ST_ADD2: begin
          sum   <= sum + prod_pc[63:0];
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          o_val          <= zero_out ? '0 : o_clamp;
          integral_acc   <= integ_hold;
          previous_error <= err;
          state          <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_pid       <= o_val;
            out_upd       <= map_upd;
            out_a_dir     <= map_a_dir;
            out_b_dir     <= map_b_dir;
            out_a_pow     <= map_a_pow;
            out_b_pow     <= map_b_pow;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    ($signed(integral_acc) <= INT_LIM) && ($signed(integral_acc) >= -INT_LIM))
    else $error("stored integral outside +/-255");

  a_pid_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(out_pid) <= 9'sd254) && ($signed(out_pid) >= -9'sd254))
    else $error("pid_value outside +/-254");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_upd) |->
      (out_a_dir == DIR_STOP) && (out_b_dir == DIR_STOP) &&
      (out_a_pow == '0) && (out_b_pow == '0))
    else $error("channel fields set without drive update");

  a_inc_quotient_width: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST) |-> (dq_a[DIV_W-1:39] == '0))
    else $error("integral increment quotient too wide");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for pid_motor_drive_controller_core: directed and random control
// steps in all four drive modes, each output checked against an in-bench PID and mix model.
// Depends on pmd_pkg and the core RTL.

import pmd_pkg::*;

localparam longint PID_CAP   = 254;
localparam longint INTEG_CAP = 255;
localparam longint MS_SCALE  = 1000;
localparam longint Q16_ONE   = 64'sd65536;
localparam longint Q24_ONE   = 64'sd16777216;
localparam longint DERIV_SAT = 64'sd1 << 46;

typedef struct {
  logic signed [PID_W-1:0] pid;
  logic                    upd;
  dir_t                    a_dir;
  dir_t                    b_dir;
  logic [POWER_W-1:0]      a_pow;
  logic [POWER_W-1:0]      b_pow;
} drive_result_t;

class pid_drive_model;
  mode_t         mode;
  longint        setpoint;
  longint        base_power;
  longint        kp;
  longint        ki;
  longint        kd;
  longint        integ_acc;
  longint        last_err;
  drive_result_t queued_outputs[$];
  int            mismatches;
  int            checked;

  function new();
    mode       = MODE_STEER;
    setpoint   = 0;
    base_power = 0;
    kp         = 0;
    ki         = 0;
    kd         = 0;
    integ_acc  = 0;
    last_err   = 0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function int outstanding();
    return queued_outputs.size();
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MODE:       mode       = mode_t'(val[1:0]);
      REG_SETPOINT:   setpoint   = longint'($signed(val));
      REG_BASE_POWER: base_power = longint'(val[POWER_W-1:0]);
      REG_KP_GAIN:    kp         = longint'($signed(val));
      REG_KI_GAIN:    ki         = longint'($signed(val));
      REG_KD_GAIN:    kd         = longint'($signed(val));
      default: ;
    endcase
  endfunction

  function void note_step(logic signed [MEAS_W-1:0] meas, logic [DT_W-1:0] dt_ms);
    longint        dt;
    longint        err;
    longint        diff;
    longint        integ;
    longint        rate;
    longint        sum;
    longint        o;
    drive_result_t r;
    dt    = longint'(dt_ms);
    err   = setpoint - longint'(meas);
    diff  = err - last_err;
    integ = integ_acc + (err * dt * Q16_ONE) / MS_SCALE;
    if (dt == 0) begin
      rate = (diff > 0) ? DERIV_SAT : ((diff < 0) ? -DERIV_SAT : 0);
    end else begin
      rate = (diff * MS_SCALE * Q16_ONE) / dt;
    end
    sum = clip(kp * err * Q16_ONE + ki * integ + kd * rate,
               -PID_CAP * Q24_ONE, PID_CAP * Q24_ONE);
    o = sum / Q24_ONE;
    if (err == 0 || integ > INTEG_CAP * Q16_ONE || integ < -INTEG_CAP * Q16_ONE) begin
      integ = 0;
      o     = 0;
    end
    integ_acc = integ;
    last_err  = err;

    r.pid   = o[PID_W-1:0];
    r.upd   = 1'b0;
    r.a_dir = DIR_STOP;
    r.b_dir = DIR_STOP;
    r.a_pow = '0;
    r.b_pow = '0;
    case (mode)
      MODE_STEER: begin
        r.upd   = 1'b1;
        r.a_dir = DIR_FWD;
        r.b_dir = DIR_FWD;
        r.a_pow = 8'(clip(base_power - o, 0, 255));
        r.b_pow = 8'(clip(base_power + o, 0, 255));
      end
      MODE_FOLLOW: begin
        if (o < 0) begin
          r.upd   = 1'b1;
          r.a_dir = DIR_FWD;
          r.b_dir = DIR_FWD;
          r.a_pow = 8'(clip(base_power + o, 0, 255));
          r.b_pow = r.a_pow;
        end else if (o > 0) begin
          r.upd   = 1'b1;
          r.a_dir = DIR_BACK;
          r.b_dir = DIR_BACK;
          r.a_pow = 8'(o);
          r.b_pow = 8'(o);
        end
      end
      MODE_ENCODER: begin
        if (o > 0) begin
          r.upd   = 1'b1;
          r.a_dir = DIR_FWD;
          r.b_dir = DIR_FWD;
          r.a_pow = 8'(o);
          r.b_pow = 8'(o);
        end else if (o < 0) begin
          r.upd = 1'b1;
        end
      end
      default: begin
        if (o > 0) begin
          r.upd   = 1'b1;
          r.a_dir = DIR_FWD;
          r.b_dir = DIR_BACK;
          r.a_pow = 8'(o);
          r.b_pow = 8'(o);
        end else if (o < 0) begin
          r.upd   = 1'b1;
          r.a_dir = DIR_BACK;
          r.b_dir = DIR_FWD;
          r.a_pow = 8'(-o);
          r.b_pow = 8'(-o);
        end
      end
    endcase
    queued_outputs.push_back(r);
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_output(logic [OUT_DATA_W-1:0] data);
    drive_result_t want;
    checked++;
    if (queued_outputs.size() == 0) begin
      mismatches++;
      $display("%0t ns: output with no request pending, expected none, actual %h",
               $time, data);
      return;
    end
    want = queued_outputs.pop_front();
    compare_field("pid_value", longint'(want.pid), longint'($signed(data[8:0])));
    compare_field("drive_update", longint'(want.upd), longint'(data[9]));
    compare_field("chan_a_dir", longint'(want.a_dir), longint'(data[11:10]));
    compare_field("chan_b_dir", longint'(want.b_dir), longint'(data[13:12]));
    compare_field("chan_a_power", longint'(want.a_pow), longint'(data[21:14]));
    compare_field("chan_b_power", longint'(want.b_pow), longint'(data[29:22]));
    compare_field("pad bits", 0, longint'(data[31:30]));
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 150;
  localparam int RANDOM_PHASES   = 17;
  localparam int PHASE_STEPS     = 100;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  pid_drive_model drive_model;
  int             steps_sent;
  int             outputs_seen;
  int             settings_loaded;
  int             tx_calm;
  int             rx_calm;

  pid_motor_drive_controller_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] pick_gain();
    int v;
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: begin
        v = int'($urandom_range(0, 1536)) - 768;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic logic [15:0] near_setpoint(logic [15:0] sp, int span);
    int mv;
    mv = int'($signed(sp)) + int'($urandom_range(0, 2 * span)) - span;
    if (mv > 32767) mv = 32767;
    if (mv < -32768) mv = -32768;
    return mv[15:0];
  endfunction

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (drive_model.outstanding() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input mode_t m, input logic [15:0] sp,
                               input logic [7:0] base, input logic [15:0] kp,
                               input logic [15:0] ki, input logic [15:0] kd);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{REG_MODE, REG_SETPOINT, REG_BASE_POWER, REG_KP_GAIN, REG_KI_GAIN, REG_KD_GAIN};
    val = '{16'(m), sp, 16'(base), kp, ki, kd};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      drive_model.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_step(input logic signed [MEAS_W-1:0] meas, input logic [DT_W-1:0] dt_ms);
    int wait_cycles;
    wait_cycles = draw_wait(tx_calm);
    if (wait_cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt_ms, meas};
    do @(posedge clk); while (!s_axis_tready);
    drive_model.note_step(meas, dt_ms);
    steps_sent++;
  endtask

  task automatic run_random_phase(input int count);
    mode_t       m;
    logic [15:0] sp;
    logic [7:0]  base;
    logic [15:0] meas;
    logic [15:0] dt;
    int          v;
    m = mode_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: sp = 16'h7FFF;
      1: sp = 16'h8000;
      default: begin
        v  = int'($urandom_range(0, 4000)) - 2000;
        sp = v[15:0];
      end
    endcase
    case ($urandom_range(0, 7))
      0: base = 8'd0;
      1: base = 8'd255;
      default: base = 8'($urandom_range(0, 255));
    endcase
    quiesce();
    load_settings(m, sp, base, pick_gain(), pick_gain(), pick_gain());
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin
          meas = 16'($urandom);
          dt   = 16'($urandom);
        end
        1: begin
          meas = near_setpoint(sp, 200);
          dt   = 16'd0;
        end
        2: begin
          meas = sp;
          dt   = 16'($urandom_range(1, 100));
        end
        3: begin
          meas = near_setpoint(sp, 300);
          dt   = 16'($urandom);
        end
        default: begin
          meas = near_setpoint(sp, $urandom_range(0, 300));
          dt   = 16'($urandom_range(1, 120));
        end
      endcase
      send_step(meas, dt);
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = draw_wait(rx_calm);
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      drive_model.check_output(m_axis_tdata);
      outputs_seen++;
      if (outputs_seen == 300 || outputs_seen == 1100) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no request moved for %0d cycles, %0d outputs outstanding",
             $time, STALL_LIMIT, drive_model.outstanding());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    steps_sent      = 0;
    outputs_seen    = 0;
    settings_loaded = 0;
    tx_calm         = 0;
    rx_calm         = 0;
    drive_model     = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    load_settings(MODE_STEER, 16'h0000, 8'd128, 16'h0100, 16'h0000, 16'h0000);
    send_step(16'sd0, 16'd10);
    send_step(-16'sd100, 16'd10);
    send_step(16'sd100, 16'd10);
    send_step(16'sd32767, 16'd10);
    send_step(16'h8000, 16'd0);

    quiesce();
    load_settings(MODE_FOLLOW, 16'h8000, 8'd255, 16'h8000, 16'h0000, 16'h0000);
    send_step(16'h8000, 16'd5);
    send_step(-16'sd32700, 16'd1);
    send_step(16'sd32767, 16'd1);

    quiesce();
    load_settings(MODE_ENCODER, 16'h7FFF, 8'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_step(16'sd32767, 16'd5);
    send_step(16'sd32760, 16'd0);
    send_step(16'sd32760, 16'd0);
    send_step(16'sd32765, 16'd0);
    send_step(16'sd32766, 16'hFFFF);

    quiesce();
    load_settings(MODE_SPIN, 16'h0000, 8'd100, 16'h0180, 16'h0100, 16'h0008);
    send_step(-16'sd50, 16'd20);
    send_step(16'sd50, 16'd20);
    send_step(16'sd3, 16'd20);
    send_step(16'sd0, 16'd20);
    send_step(16'sd10, 16'hFFFF);
    send_step(-16'sd1, 16'd1);

    quiesce();
    load_settings(MODE_FOLLOW, 16'h0000, 8'd50, 16'h0100, 16'h0000, 16'h0000);
    send_step(16'sd100, 16'd10);
    send_step(-16'sd20, 16'd10);
    send_step(16'sd0, 16'd10);

    quiesce();
    load_settings(MODE_ENCODER, 16'h0000, 8'd0, 16'h0100, 16'h0000, 16'h0000);
    send_step(-16'sd30, 16'd10);
    send_step(16'sd30, 16'd10);
    send_step(16'sd0, 16'd10);

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(PHASE_STEPS);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d control steps over %0d register settings across all drive modes.",
             steps_sent, settings_loaded);
    $display("Checked %0d outputs field by field; %0d field mismatches.",
             drive_model.checked, drive_model.mismatches);
    if (drive_model.mismatches == 0 && drive_model.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pmd_pkg.sv
sv/pid_motor_drive_controller_core.sv
tb/tb.sv
